// ----- design/assert_macros.svh -----
// assertion macros used by the monitor design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge, off while reset is applied
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication: when cond holds, prop holds on the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)

`endif

`endif

// ----- design/clhm_pkg.sv -----
// types and constants of the charge limit hysteresis monitor
package clhm_pkg;

	localparam int unsigned PCT_W = 7;
	localparam int unsigned CMP_W = PCT_W + 1;

	// hysteresis band and overshoot margins in percent
	localparam logic [CMP_W-1:0] HYST_BAND    = CMP_W'(5);
	localparam logic [CMP_W-1:0] NAV_MARGIN   = CMP_W'(2);
	localparam logic [CMP_W-1:0] ENDUR_MARGIN = CMP_W'(1);

	typedef enum logic [1:0] {
		CFG_NAV_ENABLE    = 2'd0,
		CFG_NAV_LIMIT     = 2'd1,
		CFG_ENDUR_ENABLE  = 2'd2,
		CFG_ENDUR_LIMIT   = 2'd3
	} cfg_index_t;

	localparam logic [1:0] REP_NONE = 2'd0;
	localparam logic [1:0] REP_ON   = 2'd1;
	localparam logic [1:0] REP_OFF  = 2'd2;

	typedef struct packed {
		logic       endur_overshoot;
		logic [1:0] endur_report;
		logic       nav_overshoot;
		logic [1:0] nav_report;
		logic       endur_stop;
		logic       nav_stop;
	} result_t;

endpackage

// ----- design/charge_limit_hysteresis_monitor.sv -----
// charge limit hysteresis monitor: navigation and endurance charge-stop features
// an accepted input is registered in the input stage, then its result in the result register
// throughput: one input transaction per cycle while m_tready keeps up, one result per input
// input register and result register are decoupled, so one input is taken while a result waits
// reset (arst_n low, asynchronous): config registers 0, state cleared, suppress marks set
`include "assert_macros.svh"

module charge_limit_hysteresis_monitor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [6:0] charge_pct, [7] zero
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] nav_stop, [1] endur_stop, [3:2] nav_report,
	                              // [4] nav_overshoot, [6:5] endur_report, [7] endur_overshoot
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);

	localparam int unsigned PW = clhm_pkg::PCT_W;
	localparam int unsigned CW = clhm_pkg::CMP_W;

	// configuration registers
	logic          nav_enable_q;
	logic [PW-1:0] nav_limit_q;
	logic          endur_enable_q;
	logic [PW-1:0] endur_limit_q;

	// feature state
	logic nav_active_q, endur_active_q, ctrl_mark_q;
	logic nav_prev_en_q, endur_prev_en_q;
	logic nav_suppress_q, endur_suppress_q;
	logic nav_stop_q, endur_stop_q;

	// input stage and result register
	logic              valid_s1;
	logic [PW-1:0]     pct_s1;
	logic              out_valid_q;
	clhm_pkg::result_t out_q;

	logic advance;
	logic cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	// compare logic
	logic [CW-1:0] c8, ln8, le8;
	logic nav_ge, nav_low, nav_over_ge, endur_ge, endur_low, endur_over_ge;
	logic nav_set, nav_clr, endur_set, endur_clr;
	logic nav_chg, endur_chg;
	logic nav_active_d, nav_stop_d, ctrl_mark_d, nav_supp_mid, nav_suppress_d;
	logic endur_active_d, endur_stop_d, endur_supp_mid, endur_suppress_d;
	clhm_pkg::result_t res_d;

	always_comb begin
		c8  = {1'b0, pct_s1};
		ln8 = {1'b0, nav_limit_q};
		le8 = {1'b0, endur_limit_q};

		nav_ge        = c8 >= ln8;
		// c <= L-5 written as c+5 <= L, false for limits below five
		nav_low       = (c8 + clhm_pkg::HYST_BAND) <= ln8;
		nav_over_ge   = c8 >= (ln8 + clhm_pkg::NAV_MARGIN);
		endur_ge      = c8 >= le8;
		endur_low     = (c8 + clhm_pkg::HYST_BAND) <= le8;
		endur_over_ge = c8 >= (le8 + clhm_pkg::ENDUR_MARGIN);

		nav_chg   = nav_enable_q != nav_prev_en_q;
		endur_chg = endur_enable_q != endur_prev_en_q;

		// navigation
		nav_set = nav_enable_q && nav_ge && !nav_active_q;
		nav_clr = ctrl_mark_q && ((nav_active_q && (!nav_enable_q || nav_low)) ||
			(!nav_enable_q && !nav_active_q));
		nav_active_d = nav_active_q;
		nav_stop_d   = nav_stop_q;
		ctrl_mark_d  = ctrl_mark_q;
		priority if (nav_set) begin
			nav_active_d = 1'b1;
			nav_stop_d   = 1'b1;
			ctrl_mark_d  = 1'b1;
		end else if (nav_clr) begin
			nav_active_d = 1'b0;
			nav_stop_d   = 1'b0;
			ctrl_mark_d  = 1'b0;
		end

		nav_supp_mid = (nav_chg && nav_enable_q) ? nav_ge : nav_suppress_q;
		res_d.nav_overshoot = nav_over_ge && nav_active_d && !nav_supp_mid;
		nav_suppress_d = nav_supp_mid || res_d.nav_overshoot;
		res_d.nav_report = !nav_chg ? clhm_pkg::REP_NONE :
			(nav_enable_q ? clhm_pkg::REP_ON : clhm_pkg::REP_OFF);

		// endurance, stop held inside the band just below the limit
		endur_set = (endur_enable_q && endur_ge) || (endur_active_q && !endur_low && !endur_ge);
		endur_clr = (endur_active_q && (!endur_enable_q || endur_low)) ||
			(!endur_enable_q && !endur_active_q);
		endur_active_d = endur_active_q;
		endur_stop_d   = endur_stop_q;
		priority if (endur_set) begin
			endur_active_d = 1'b1;
			endur_stop_d   = 1'b1;
		end else if (endur_clr) begin
			endur_active_d = 1'b0;
			endur_stop_d   = 1'b0;
		end

		endur_supp_mid = (endur_chg && endur_enable_q) ? endur_ge : endur_suppress_q;
		res_d.endur_overshoot = endur_over_ge && endur_active_d && !endur_supp_mid;
		endur_suppress_d = endur_supp_mid || res_d.endur_overshoot;
		res_d.endur_report = !endur_chg ? clhm_pkg::REP_NONE :
			(endur_enable_q ? clhm_pkg::REP_ON : clhm_pkg::REP_OFF);

		res_d.nav_stop   = nav_stop_d;
		res_d.endur_stop = endur_stop_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nav_enable_q   <= 1'b0;
			nav_limit_q    <= '0;
			endur_enable_q <= 1'b0;
			endur_limit_q  <= '0;
		end else if (cfg_wr) begin
			unique case (clhm_pkg::cfg_index_t'(cfg_index))
				clhm_pkg::CFG_NAV_ENABLE:   nav_enable_q   <= cfg_data[0];
				clhm_pkg::CFG_NAV_LIMIT:    nav_limit_q    <= cfg_data;
				clhm_pkg::CFG_ENDUR_ENABLE: endur_enable_q <= cfg_data[0];
				clhm_pkg::CFG_ENDUR_LIMIT:  endur_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// feature state, config writes should only come while idle; the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nav_active_q     <= 1'b0;
			endur_active_q   <= 1'b0;
			ctrl_mark_q      <= 1'b0;
			nav_prev_en_q    <= 1'b0;
			endur_prev_en_q  <= 1'b0;
			nav_suppress_q   <= 1'b1;
			endur_suppress_q <= 1'b1;
			nav_stop_q       <= 1'b0;
			endur_stop_q     <= 1'b0;
		end else if (advance) begin
			nav_active_q     <= nav_active_d;
			endur_active_q   <= endur_active_d;
			ctrl_mark_q      <= ctrl_mark_d;
			nav_prev_en_q    <= nav_enable_q;
			endur_prev_en_q  <= endur_enable_q;
			nav_suppress_q   <= nav_suppress_d;
			endur_suppress_q <= endur_suppress_d;
			nav_stop_q       <= nav_stop_d;
			endur_stop_q     <= endur_stop_d;
		end else if (cfg_wr) begin
			if (cfg_index == clhm_pkg::CFG_NAV_ENABLE || cfg_index == clhm_pkg::CFG_NAV_LIMIT) begin
				nav_active_q <= 1'b0;
			end else begin
				endur_active_q <= 1'b0;
			end
		end
	end

	// input stage valid and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pct_s1 <= s_tdata[PW-1:0];
		end
		if (advance) begin
			out_q <= res_d;
		end
	end

	`ASSERT_CLK(a_nav_active_stops, clk, arst_n, !nav_active_q || nav_stop_q, "nav active without stop")
	`ASSERT_CLK(a_nav_active_mark, clk, arst_n, !nav_active_q || ctrl_mark_q, "nav active without mark")
	`ASSERT_CLK(a_endur_active_stops, clk, arst_n, !endur_active_q || endur_stop_q, "endur active without stop")
	`ASSERT_NEXT(a_nav_over_once, clk, arst_n, advance && res_d.nav_overshoot, nav_suppress_q, "nav overshoot not suppressed")
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, advance, m_tvalid, "result lost after transaction")

endmodule

// ----- sim/charge_limit_hysteresis_monitor_test.sv -----
// self-checking testbench of the charge limit hysteresis monitor
`timescale 1ns / 100ps

module charge_limit_hysteresis_monitor_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 25;
	localparam int TICKS_PER_PHASE = 37;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b1;
	logic [7:0]           m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	clhm_pkg::cfg_index_t cfg_index = clhm_pkg::CFG_NAV_ENABLE;
	logic [6:0]           cfg_data = '0;

	charge_limit_hysteresis_monitor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// register copies and feature state of the predictor
	logic       nav_en_r = 1'b0;
	logic [6:0] nav_lim_r = '0;
	logic       endur_en_r = 1'b0;
	logic [6:0] endur_lim_r = '0;
	logic       nav_on = 1'b0;
	logic       endur_on = 1'b0;
	logic       ctl_mark = 1'b0;
	logic       nav_en_last = 1'b0;
	logic       endur_en_last = 1'b0;
	logic       nav_quiet = 1'b1;
	logic       endur_quiet = 1'b1;
	logic       nav_hold = 1'b0;
	logic       endur_hold = 1'b0;

	logic [6:0]        pending_pct[$];
	clhm_pkg::result_t expected_flags[$];
	int                fail_count = 0;
	int                cycles = 0;
	int                results_seen = 0;
	bit                calm = 1'b0;

	function automatic void apply_reg(clhm_pkg::cfg_index_t idx, logic [6:0] val);
		case (idx)
			clhm_pkg::CFG_NAV_ENABLE: begin
				nav_en_r = val[0];
				nav_on = 1'b0;
			end
			clhm_pkg::CFG_NAV_LIMIT: begin
				nav_lim_r = val;
				nav_on = 1'b0;
			end
			clhm_pkg::CFG_ENDUR_ENABLE: begin
				endur_en_r = val[0];
				endur_on = 1'b0;
			end
			clhm_pkg::CFG_ENDUR_LIMIT: begin
				endur_lim_r = val;
				endur_on = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic clhm_pkg::result_t predict_tick(logic [6:0] pct);
		clhm_pkg::result_t r;
		int c, ln, le;
		logic nav_chg, endur_chg;
		r = '0;
		c = int'(pct);
		ln = int'(nav_lim_r);
		le = int'(endur_lim_r);
		nav_chg = nav_en_r != nav_en_last;
		endur_chg = endur_en_r != endur_en_last;
		nav_en_last = nav_en_r;
		endur_en_last = endur_en_r;

		if (nav_en_r && c >= ln && !nav_on) begin
			nav_on = 1'b1;
			nav_hold = 1'b1;
			ctl_mark = 1'b1;
		end else if (ctl_mark && ((nav_on && (!nav_en_r
				|| c <= ln - int'(clhm_pkg::HYST_BAND))) || (!nav_en_r && !nav_on))) begin
			nav_on = 1'b0;
			nav_hold = 1'b0;
			ctl_mark = 1'b0;
		end
		if (nav_chg) begin
			r.nav_report = nav_en_r ? clhm_pkg::REP_ON : clhm_pkg::REP_OFF;
			if (nav_en_r)
				nav_quiet = c >= ln;
		end
		if (c >= ln + int'(clhm_pkg::NAV_MARGIN) && nav_on && !nav_quiet) begin
			r.nav_overshoot = 1'b1;
			nav_quiet = 1'b1;
		end

		// endurance keeps its stop while inside the band below the limit
		if ((endur_en_r && c >= le)
				|| (endur_on && c > le - int'(clhm_pkg::HYST_BAND) && c < le)) begin
			endur_on = 1'b1;
			endur_hold = 1'b1;
		end else if ((endur_on && (!endur_en_r || c <= le - int'(clhm_pkg::HYST_BAND)))
				|| (!endur_en_r && !endur_on)) begin
			endur_on = 1'b0;
			endur_hold = 1'b0;
		end
		if (endur_chg) begin
			r.endur_report = endur_en_r ? clhm_pkg::REP_ON : clhm_pkg::REP_OFF;
			if (endur_en_r)
				endur_quiet = c >= le;
		end
		if (c >= le + int'(clhm_pkg::ENDUR_MARGIN) && endur_on && !endur_quiet) begin
			r.endur_overshoot = 1'b1;
			endur_quiet = 1'b1;
		end

		r.nav_stop = nav_hold;
		r.endur_stop = endur_hold;
		return r;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [6:0] pick_limit();
		if ($urandom_range(0, 3) != 0)
			return 7'($urandom_range(0, 100));
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd4;
			3: return 7'd5;
			4: return 7'd100;
			default: return 7'd127;
		endcase
	endfunction

	task automatic check_field(string name, int want, int seen);
		if (want != seen) begin
			$error("%s expected %0d actual %0d", name, want, seen);
			fail_count++;
		end
	endtask

	task automatic write_reg(clhm_pkg::cfg_index_t idx, logic [6:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_pct.size() != 0 || s_tvalid || expected_flags.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// input driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_flags.push_back(predict_tick(s_tdata[6:0]));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_pct.size() != 0) begin
					s_tdata <= {1'b0, pending_pct.pop_front()};
					s_tvalid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor, with a long hold-off now and then to back up the block
	int stall_left = 0;
	int holds_done = 0;
	always @(posedge clk) begin
		clhm_pkg::result_t want, got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = clhm_pkg::result_t'(m_tdata);
				results_seen++;
				if (expected_flags.size() == 0) begin
					$error("result transaction with nothing expected: %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_flags.pop_front();
					check_field("nav_stop", int'(want.nav_stop), int'(got.nav_stop));
					check_field("endur_stop", int'(want.endur_stop), int'(got.endur_stop));
					check_field("nav_report", int'(want.nav_report), int'(got.nav_report));
					check_field("nav_overshoot", int'(want.nav_overshoot),
						int'(got.nav_overshoot));
					check_field("endur_report", int'(want.endur_report),
						int'(got.endur_report));
					check_field("endur_overshoot", int'(want.endur_overshoot),
						int'(got.endur_overshoot));
				end
				if (holds_done < 2 && results_seen > 60 + 400 * holds_done
						&& pending_pct.size() > 10) begin
					stall_left = 120;
					holds_done++;
				end else begin
					stall_left = pick_gap();
				end
			end
			m_tready <= stall_left == 0;
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int level, dir, top, bottom, lo_lim, hi_lim;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// limits around mid range: stop, overshoot, band hold and resume on both features
		write_reg(clhm_pkg::CFG_NAV_ENABLE, 7'd1);
		write_reg(clhm_pkg::CFG_NAV_LIMIT, 7'd80);
		write_reg(clhm_pkg::CFG_ENDUR_ENABLE, 7'd1);
		write_reg(clhm_pkg::CFG_ENDUR_LIMIT, 7'd60);
		pending_pct = '{7'd0, 7'd30, 7'd60, 7'd61, 7'd62, 7'd80, 7'd81, 7'd82, 7'd83,
			7'd100, 7'd127, 7'd76, 7'd75, 7'd74, 7'd56, 7'd55, 7'd54, 7'd64};
		wait_drained();

		// limits below the band width: only a disable releases the stop
		write_reg(clhm_pkg::CFG_NAV_LIMIT, 7'd3);
		write_reg(clhm_pkg::CFG_ENDUR_LIMIT, 7'd2);
		pending_pct = '{7'd3, 7'd4, 7'd6, 7'd0, 7'd1, 7'd127};
		wait_drained();
		write_reg(clhm_pkg::CFG_NAV_ENABLE, 7'd0);
		write_reg(clhm_pkg::CFG_ENDUR_ENABLE, 7'd0);
		pending_pct.push_back(7'd2);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			calm = $urandom_range(0, 3) == 0;
			if ($urandom_range(0, 1))
				write_reg(clhm_pkg::CFG_NAV_ENABLE, 7'($urandom_range(0, 9) < 7));
			if ($urandom_range(0, 1))
				write_reg(clhm_pkg::CFG_NAV_LIMIT, pick_limit());
			if ($urandom_range(0, 1))
				write_reg(clhm_pkg::CFG_ENDUR_ENABLE, 7'($urandom_range(0, 9) < 7));
			if ($urandom_range(0, 1))
				write_reg(clhm_pkg::CFG_ENDUR_LIMIT, pick_limit());

			// charge sweeps up and down across both limits, with some random jumps
			lo_lim = nav_lim_r < endur_lim_r ? int'(nav_lim_r) : int'(endur_lim_r);
			hi_lim = nav_lim_r > endur_lim_r ? int'(nav_lim_r) : int'(endur_lim_r);
			top = hi_lim + 4 > 127 ? 127 : hi_lim + 4;
			bottom = lo_lim < 8 ? 0 : lo_lim - 8;
			level = $urandom_range(bottom, top);
			dir = $urandom_range(0, 1) ? 1 : -1;
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					pending_pct.push_back(7'($urandom_range(0, 127)));
				end else begin
					level += dir * int'($urandom_range(0, 3));
					if (level >= top) begin
						level = top;
						dir = -1;
					end else if (level <= bottom) begin
						level = bottom;
						dir = 1;
					end
					pending_pct.push_back(7'(level));
				end
			end
			wait_drained();
		end

		calm = 1'b0;
		wait_drained();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/clhm_pkg.sv
design/charge_limit_hysteresis_monitor.sv
sim/charge_limit_hysteresis_monitor_test.sv
